// File: rtl/core/smpq_pkg.sv
// Shared types and constants of the stable max priority queue.
package smpq_pkg;

  localparam int TAG_W = 16;
  localparam int SEV_W = 16;
  localparam int ENTRY_W = TAG_W + SEV_W;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_SERVE  = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  localparam logic [1:0] ST_SERVED = 2'd0;
  localparam logic [1:0] ST_EMPTY  = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_EMIT,
    S_SHIFT
  } smpq_state_t;

  typedef struct packed {
    logic       ins;
    logic       clr;
    logic       start_scan;
    logic       scan;
    logic       emit;
    logic [1:0] emit_status;
    logic       start_shift;
    logic       shift;
    logic       dec;
  } smpq_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic scan_done;
    logic shift_done;
    logic out_free;
  } smpq_sts_t;

endpackage

// File: rtl/core/stable_max_priority_queue.sv
// Insert and clear words need no result; a full insert or an empty serve emits a status word.
// A serve with stored entries runs in steps: accept, scan the entry RAM, emit the result,
// then close the gap. One word is in work at a time; a result still waiting in the output
// register holds the emit step. Synchronous active-low reset empties the queue by zeroing
// the fill count; the RAM itself is not swept.
module stable_max_priority_queue #(
  parameter int CAPACITY = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 in_op,
  input  logic [smpq_pkg::TAG_W-1:0] in_entry_tag,
  input  logic [smpq_pkg::SEV_W-1:0] in_entry_severity,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [1:0]                 out_status,
  output logic [smpq_pkg::TAG_W-1:0] out_served_tag,
  output logic [smpq_pkg::SEV_W-1:0] out_served_severity
);

  smpq_pkg::smpq_cmd_t cmd;
  smpq_pkg::smpq_sts_t sts;

  smpq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_op    (in_op),
    .sts      (sts),
    .cmd      (cmd)
  );

  smpq_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_entry_tag        (in_entry_tag),
    .in_entry_severity   (in_entry_severity),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_status          (out_status),
    .out_served_tag      (out_served_tag),
    .out_served_severity (out_served_severity)
  );

endmodule

// File: rtl/core/smpq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module smpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/core/smpq_ctrl.sv
// Controller state machine of the stable max priority queue.
module smpq_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_op,
  input  smpq_pkg::smpq_sts_t sts,
  output smpq_pkg::smpq_cmd_t cmd
);

  smpq_pkg::smpq_state_t state_r, state_nxt;
  logic [1:0]            code_r, code_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= smpq_pkg::S_IDLE;
      code_r  <= smpq_pkg::ST_SERVED;
    end else begin
      state_r <= state_nxt;
      code_r  <= code_nxt;
    end
  end

  // Next state and the status code of the pending result.
  always_comb begin
    state_nxt = state_r;
    code_nxt  = code_r;
    case (state_r)
      smpq_pkg::S_IDLE: begin
        if (in_valid) begin
          case (in_op)
            smpq_pkg::OP_INSERT: begin
              if (sts.full) begin
                state_nxt = smpq_pkg::S_EMIT;
                code_nxt  = smpq_pkg::ST_FULL;
              end
            end
            smpq_pkg::OP_SERVE: begin
              if (sts.empty) begin
                state_nxt = smpq_pkg::S_EMIT;
                code_nxt  = smpq_pkg::ST_EMPTY;
              end else begin
                state_nxt = smpq_pkg::S_SCAN;
                code_nxt  = smpq_pkg::ST_SERVED;
              end
            end
            default: begin
              state_nxt = smpq_pkg::S_IDLE;
            end
          endcase
        end
      end
      smpq_pkg::S_SCAN: begin
        if (sts.scan_done) begin
          state_nxt = smpq_pkg::S_EMIT;
        end
      end
      smpq_pkg::S_EMIT: begin
        if (sts.out_free) begin
          if (code_r == smpq_pkg::ST_SERVED) begin
            state_nxt = smpq_pkg::S_SHIFT;
          end else begin
            state_nxt = smpq_pkg::S_IDLE;
          end
        end
      end
      smpq_pkg::S_SHIFT: begin
        if (sts.shift_done) begin
          state_nxt = smpq_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = smpq_pkg::S_IDLE;
      end
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      smpq_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (in_op)
            smpq_pkg::OP_INSERT: cmd.ins        = !sts.full;
            smpq_pkg::OP_SERVE:  cmd.start_scan = !sts.empty;
            smpq_pkg::OP_CLEAR:  cmd.clr        = 1'b1;
            default:             cmd            = '0;
          endcase
        end
      end
      smpq_pkg::S_SCAN: begin
        cmd.scan = 1'b1;
      end
      smpq_pkg::S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = code_r;
          cmd.start_shift = (code_r == smpq_pkg::ST_SERVED);
        end
      end
      smpq_pkg::S_SHIFT: begin
        cmd.shift = 1'b1;
        cmd.dec   = sts.shift_done;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// File: rtl/core/smpq_datapath.sv
// Datapath of the stable max priority queue: entry RAM, scan and shift walker, result word.
module smpq_datapath #(
  parameter int CAPACITY = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  smpq_pkg::smpq_cmd_t                 cmd,
  output smpq_pkg::smpq_sts_t                 sts,
  input  logic [smpq_pkg::TAG_W-1:0]          in_entry_tag,
  input  logic [smpq_pkg::SEV_W-1:0]          in_entry_severity,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [1:0]                          out_status,
  output logic [smpq_pkg::TAG_W-1:0]          out_served_tag,
  output logic [smpq_pkg::SEV_W-1:0]          out_served_severity
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] ptr_r, ptr_nxt;
  logic          pend_r, pend_nxt;
  logic [AW-1:0] pidx_r, pidx_nxt;

  logic [AW-1:0]              best_idx_r, best_idx_nxt;
  logic [smpq_pkg::TAG_W-1:0] best_tag_r, best_tag_nxt;
  logic [smpq_pkg::SEV_W-1:0] best_sev_r, best_sev_nxt;
  logic                       best_any_r, best_any_nxt;

  logic                       out_valid_r, out_valid_nxt;
  logic [1:0]                 out_status_r, out_status_nxt;
  logic [smpq_pkg::TAG_W-1:0] out_tag_r, out_tag_nxt;
  logic [smpq_pkg::SEV_W-1:0] out_sev_r, out_sev_nxt;

  logic                          ram_we;
  logic [AW-1:0]                 ram_waddr;
  logic [smpq_pkg::ENTRY_W-1:0]  ram_wdata;
  logic [smpq_pkg::ENTRY_W-1:0]  ram_rdata;
  logic [smpq_pkg::TAG_W-1:0]    rd_tag;
  logic [smpq_pkg::SEV_W-1:0]    rd_sev;
  logic                          walk;
  logic                          issue;

  smpq_ram #(
    .WIDTH (smpq_pkg::ENTRY_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ptr_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  assign rd_tag = ram_rdata[smpq_pkg::ENTRY_W-1:smpq_pkg::SEV_W];
  assign rd_sev = ram_rdata[smpq_pkg::SEV_W-1:0];
  assign walk   = cmd.scan || cmd.shift;
  assign issue  = walk && (ptr_r < cnt_r);

  assign sts.full       = (cnt_r == CW'(CAPACITY));
  assign sts.empty      = (cnt_r == '0);
  assign sts.scan_done  = (ptr_r == cnt_r) && !pend_r;
  assign sts.shift_done = (ptr_r == cnt_r) && !pend_r;
  assign sts.out_free   = !out_valid_r || out_ready;

  // Entries sit in insertion order; a serve closes the gap by moving later entries down.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cnt_r[AW-1:0];
    ram_wdata = {in_entry_tag, in_entry_severity};
    if (cmd.ins) begin
      ram_we = 1'b1;
    end else if (cmd.shift && pend_r) begin
      ram_we    = 1'b1;
      ram_waddr = pidx_r - AW'(1);
      ram_wdata = ram_rdata;
    end
  end

  always_comb begin
    cnt_nxt      = cnt_r;
    ptr_nxt      = ptr_r;
    pend_nxt     = pend_r;
    pidx_nxt     = pidx_r;
    best_idx_nxt = best_idx_r;
    best_tag_nxt = best_tag_r;
    best_sev_nxt = best_sev_r;
    best_any_nxt = best_any_r;

    if (cmd.clr) begin
      cnt_nxt = '0;
    end else if (cmd.ins) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (cmd.dec) begin
      cnt_nxt = cnt_r - CW'(1);
    end

    if (cmd.start_scan) begin
      ptr_nxt      = '0;
      pend_nxt     = 1'b0;
      best_any_nxt = 1'b0;
    end else if (cmd.start_shift) begin
      ptr_nxt  = CW'(best_idx_r) + CW'(1);
      pend_nxt = 1'b0;
    end else if (walk) begin
      pend_nxt = issue;
      if (issue) begin
        pidx_nxt = ptr_r[AW-1:0];
        ptr_nxt  = ptr_r + CW'(1);
      end
    end

    // Strictly greater keeps the earliest entry among equal severities.
    if (cmd.scan && pend_r && (!best_any_r || (rd_sev > best_sev_r))) begin
      best_any_nxt = 1'b1;
      best_idx_nxt = pidx_r;
      best_tag_nxt = rd_tag;
      best_sev_nxt = rd_sev;
    end
  end

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_tag_nxt    = out_tag_r;
    out_sev_nxt    = out_sev_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.emit) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = cmd.emit_status;
      if (cmd.emit_status == smpq_pkg::ST_SERVED) begin
        out_tag_nxt = best_tag_r;
        out_sev_nxt = best_sev_r;
      end else begin
        out_tag_nxt = '0;
        out_sev_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      ptr_r       <= '0;
      pend_r      <= 1'b0;
      best_any_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      ptr_r       <= ptr_nxt;
      pend_r      <= pend_nxt;
      best_any_r  <= best_any_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pidx_r       <= pidx_nxt;
    best_idx_r   <= best_idx_nxt;
    best_tag_r   <= best_tag_nxt;
    best_sev_r   <= best_sev_nxt;
    out_status_r <= out_status_nxt;
    out_tag_r    <= out_tag_nxt;
    out_sev_r    <= out_sev_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_served_tag      = out_tag_r;
  assign out_served_severity = out_sev_r;

endmodule

// File: rtl/core/smpq_checker.sv
// Port-level checker of the stable max priority queue and its bind.
module smpq_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic [1:0]                 in_op,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [1:0]                 out_status,
  input logic [smpq_pkg::TAG_W-1:0] out_served_tag,
  input logic [smpq_pkg::SEV_W-1:0] out_served_severity
);

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_served_tag) && $stable(out_served_severity))
    else $error("result word changed while stalled");

  // Only a served result carries a tag and severity.
  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != smpq_pkg::ST_SERVED) |->
      (out_served_tag == '0) && (out_served_severity == '0))
    else $error("empty or full result carries nonzero fields");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == smpq_pkg::ST_SERVED) ||
      (out_status == smpq_pkg::ST_EMPTY) || (out_status == smpq_pkg::ST_FULL))
    else $error("result status is not a defined code");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // A clear finishes in its own cycle and leaves the block ready.
  a_clear_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_op == smpq_pkg::OP_CLEAR) |=> in_ready)
    else $error("not ready after a clear");

endmodule

bind stable_max_priority_queue smpq_checker u_smpq_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_valid),
  .in_ready            (in_ready),
  .in_op               (in_op),
  .out_valid           (out_valid),
  .out_ready           (out_ready),
  .out_status          (out_status),
  .out_served_tag      (out_served_tag),
  .out_served_severity (out_served_severity)
);
